>>> design/skc_pkg.sv
// shared constants, register indexes and tables for the soft-knee compressor
// no dependencies; every other file but skc_fifo refers to it by scoped names
package skc_pkg;

  // default widths handed to the top level parameters
  localparam int SAMPLE_BITS_DEF  = 24;
  localparam int DB_FRAC_BITS_DEF = 8;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] REG_MAKEUP  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_THRESH  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_INV_RAT = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_KNEE    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_ATTACK  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_RELEASE = 3'd5;

  // register reset values
  localparam logic [16:0] INV_RATIO_RST = 17'd65536;
  localparam logic [15:0] ATTACK_RST    = 16'd65400;
  localparam logic [15:0] RELEASE_RST   = 16'd65468;

  // detector level in Q8.16: reset value and ceiling
  localparam logic [23:0] DET_RESET = 24'd655;
  localparam logic [23:0] DET_MAX   = 24'd8388607;

  // fixed-point constants
  localparam logic signed [20:0] K_DB_PER_LOG2 = 21'sd394566;
  localparam logic signed [14:0] K_LOG2_PER_DB = 15'sd10885;
  localparam logic [29:0]        LN2_Q30       = 30'd744261118;
  localparam logic [31:0]        ONE_Q30       = 32'd1073741824;
  localparam logic [23:0]        RECIP5_Q26    = 24'd13421773;

  // floor((2^32-1)/k) for the horner divide by step index
  function automatic logic [31:0] horner_recip(input logic [2:0] k);
    logic [31:0] r;
    case (k)
      3'd1: r = 32'd4294967295;
      3'd2: r = 32'd2147483647;
      3'd3: r = 32'd1431655765;
      3'd4: r = 32'd1073741823;
      3'd5: r = 32'd858993459;
      3'd6: r = 32'd715827882;
      3'd7: r = 32'd613566756;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

>>> design/skc_if.sv
// stream interfaces for the sample and result channels
// depends on skc_pkg for default widths
interface skc_in_if #(
  parameter int SAMPLE_BITS = skc_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          block_start;

  modport source (output valid, output sample_in, output block_start, input ready);
  modport sink   (input valid, input sample_in, input block_start, output ready);
endinterface

interface skc_out_if #(
  parameter int SAMPLE_BITS  = skc_pkg::SAMPLE_BITS_DEF,
  parameter int DB_FRAC_BITS = skc_pkg::DB_FRAC_BITS_DEF
);
  logic                             valid;
  logic                             ready;
  logic signed [SAMPLE_BITS-1:0]    sample_out;
  logic signed [DB_FRAC_BITS+7:0]   gain_db;

  modport source (output valid, output sample_out, output gain_db, input ready);
  modport sink   (input valid, input sample_out, input gain_db, output ready);
endinterface

>>> design/skc_front.sv
// front end: takes a sample word, forms its magnitude and zero flag
// depends on skc_in_if; feeds the queue toward the back end
module skc_front #(
  parameter int SAMPLE_BITS = skc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  skc_in_if.sink                 in_ch,
  output logic                   item_valid,
  input  logic                   item_ready,
  output logic [SAMPLE_BITS+2:0] item_data
);

  localparam int SB = SAMPLE_BITS;

  logic          fv_r;
  logic [SB+2:0] item_r;
  logic          neg;
  logic [SB-1:0] mag;

  // magnitude, full-scale negative maps to 2^(SB-1)
  always_comb begin
    neg = in_ch.sample_in[SB-1];
    mag = neg ? (~in_ch.sample_in + 1'b1) : in_ch.sample_in;
  end

  assign in_ch.ready = !fv_r || item_ready;
  assign item_valid  = fv_r;
  assign item_data   = item_r;

  // one classified word held until the queue takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (in_ch.ready) begin
      fv_r <= in_ch.valid;
    end
    if (in_ch.valid && in_ch.ready) begin
      item_r <= {in_ch.block_start, (mag == '0), neg, mag};
    end
  end

endmodule

>>> design/skc_fifo.sv
// two-entry queue between the front and back ends
// no dependencies
module skc_fifo #(
  parameter int W = 27
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  logic [W-1:0] mem_r [2];
  logic         wp_r;
  logic         rp_r;
  logic [1:0]   cnt_r;
  logic         do_push;
  logic         do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = mem_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop)  rp_r <= ~rp_r;
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= push_data;
  end

endmodule

>>> design/skc_back.sv
// back end: level in dB, gain curve, detector, linear gain and multiply
// holds the configuration registers; depends on skc_pkg
module skc_back #(
  parameter int SAMPLE_BITS  = skc_pkg::SAMPLE_BITS_DEF,
  parameter int DB_FRAC_BITS = skc_pkg::DB_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  logic [SAMPLE_BITS+2:0]              item_data,
  input  logic                                cfg_we,
  input  logic [skc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [((DB_FRAC_BITS+8)>17 ? (DB_FRAC_BITS+8) : 17)-1:0] cfg_wdata,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [SAMPLE_BITS-1:0]       out_sample,
  output logic signed [DB_FRAC_BITS+7:0]      out_gain
);

  localparam int SB  = SAMPLE_BITS;
  localparam int F   = DB_FRAC_BITS;
  localparam int DB  = F + 8;
  localparam int PW  = $clog2(SB);
  localparam int LDW = PW + 39;
  localparam int EKW = F + 5;
  localparam int KXW = 2 * EKW + 17;
  localparam int KYW = KXW - (F + 19);
  localparam int OW  = SB + 33;

  localparam int DB_LO     = -(128 << F);
  localparam int DB_HI     = (128 << F) - 1;
  localparam int KNEE_W_I  = 20 << F;
  localparam logic signed [DB+1:0]  KNEE_HALF = (DB+2)'(10 << F);
  localparam logic signed [LDW-1:0] LV_RND    = LDW'(1) << (31 - F);
  localparam logic signed [DB-1:0]  LVL_FLOOR = DB'(DB_LO);
  localparam logic [OW-1:0] SMAX_P = (OW'(1) << (SB - 1)) - OW'(1);
  localparam logic [29:0] LN2_Q30_W = skc_pkg::LN2_Q30;

  typedef enum logic [4:0] {
    S_IDLE, S_NORM, S_SQR, S_L2, S_LVL, S_GAIN, S_KNEE1, S_KNEE2, S_RED,
    S_DET, S_CTRL, S_EXPE, S_EXPX, S_H1, S_H2, S_H3, S_MUL, S_OUT
  } state_t;

  typedef enum logic [1:0] {RED_ZERO, RED_SOFT, RED_LIN} red_mode_t;

  // configuration
  logic signed [DB-1:0] makeup_r;
  logic signed [DB-1:0] thr_r;
  logic [16:0]          inv_r;
  logic                 knee_r;
  logic [15:0]          att_r;
  logic [15:0]          rel_r;

  // sequencer state and datapath registers
  state_t               state_r;
  red_mode_t            mode_r;
  logic [23:0]          level_r;
  logic                 neg_r;
  logic [SB-1:0]        mag_r;
  logic [SB-1:0]        z_r;
  logic [PW-1:0]        p_r;
  logic [30:0]          y_r;
  logic [15:0]          fr_r;
  logic [3:0]           cnt_r;
  logic signed [LDW-1:0] ldb_r;
  logic signed [DB-1:0] lvl_r;
  logic [2*EKW-1:0]     ek2_r;
  logic [DB+16:0]       lin_r;
  logic [16:0]          m_r;
  logic [KXW-1:0]       kx_r;
  logic [KYW+23:0]      q5_r;
  logic [23:0]          red_r;
  logic signed [DB-1:0] g_r;
  logic signed [DB+14:0] ep_r;
  logic signed [7:0]    n_r;
  logic [29:0]          x_r;
  logic [31:0]          t_r;
  logic [2:0]           k_r;
  logic [61:0]          hp_r;
  logic [31:0]          v_r;
  logic [63:0]          qm_r;
  logic [SB+31:0]       pr_r;
  logic                 out_valid_r;
  logic signed [SB-1:0] out_sample_r;
  logic signed [DB-1:0] out_gain_r;

  // combinational helpers
  logic                 it_blk, it_zero, it_neg;
  logic [SB-1:0]        it_mag;
  logic [SB+30:0]       z_ext;
  logic [61:0]          sq;
  logic [31:0]          sq_hi;
  logic signed [PW:0]   pdiff;
  logic signed [PW+16:0] l2;
  logic signed [LDW-1:0] lsum, lsh;
  logic signed [DB:0]   d;
  logic signed [DB+1:0] d2, ek_s;
  logic [EKW-1:0]       ek;
  logic [16:0]          m_w;
  logic [KYW-1:0]       ky;
  logic [DB:0]          red_db;
  logic [24:0]          red_full;
  logic [15:0]          a_sel;
  logic [16:0]          ia;
  logic [41:0]          acc;
  logic signed [25:0]   mk, cv, gw;
  logic signed [DB+14:0] ee;
  logic [45:0]          fx;
  logic [31:0]          v_w, q0;
  logic [34:0]          prodk, rem;
  logic signed [8:0]    sv;
  logic [5:0]           shc;
  logic [OW-1:0]        rnd, qq;
  logic [SB-1:0]        res;

  assign {it_blk, it_zero, it_neg, it_mag} = item_data;
  assign item_ready = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;
  assign out_gain   = out_gain_r;

  always_comb begin
    // mantissa in Q1.30 from the normalized magnitude
    z_ext = {z_r, 31'b0};
    // one squaring step of the log2 fraction
    sq    = y_r * y_r;
    sq_hi = sq[61:30];
    // log2 in Q.16 and its conversion to dB
    pdiff = $signed({1'b0, p_r}) - $signed((PW+1)'(SB - 1));
    l2    = $signed({pdiff, fr_r});
    lsum  = ldb_r + LV_RND;
    lsh   = lsum >>> (32 - F);
    // gain computer
    d     = lvl_r - thr_r;
    d2    = $signed({d, 1'b0});
    ek_s  = d + KNEE_HALF;
    ek    = ek_s[EKW-1:0];
    m_w   = (inv_r > 17'd65536) ? 17'd0 : (17'd65536 - inv_r);
    ky    = kx_r[KXW-1:F+19];
    case (mode_r)
      RED_SOFT: red_db = (DB+1)'(q5_r[KYW+23:26]);
      RED_LIN:  red_db = lin_r[DB+16:16];
      default:  red_db = '0;
    endcase
    red_full = 25'(red_db) << (16 - F);
    // detector pole choice and update
    a_sel = (red_r > level_r) ? att_r : rel_r;
    ia    = 17'd65536 - {1'b0, a_sel};
    acc   = a_sel * level_r + ia * red_r + 42'd32768;
    // control gain
    mk    = makeup_r;
    cv    = (mk <<< (16 - F)) - $signed({2'b00, level_r});
    gw    = cv >>> (16 - F);
    // exponent split and fraction scaled by ln2
    ee    = ep_r >>> F;
    fx    = ee[15:0] * LN2_Q30_W;
    // horner step divide by k with one correction
    v_w   = hp_r[61:30];
    q0    = qm_r[63:32];
    prodk = q0 * k_r;
    rem   = {3'b000, v_r} - prodk;
    // final shift with rounding and saturation
    sv    = 9'sd30 - n_r;
    if (sv < 9'sd1) shc = 6'd1;
    else if (sv > 9'sd62) shc = 6'd62;
    else shc = sv[5:0];
    rnd   = OW'(1) << (shc - 6'd1);
    qq    = (sv > 9'sd62) ? '0 : ((OW'(pr_r) + rnd) >> shc);
    if (neg_r) begin
      if (qq > SMAX_P + OW'(1)) res = {1'b1, {(SB-1){1'b0}}};
      else res = ~qq[SB-1:0] + 1'b1;
    end else begin
      if (qq > SMAX_P) res = {1'b0, {(SB-1){1'b1}}};
      else res = qq[SB-1:0];
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      makeup_r <= '0;
      thr_r    <= '0;
      inv_r    <= skc_pkg::INV_RATIO_RST;
      knee_r   <= 1'b1;
      att_r    <= skc_pkg::ATTACK_RST;
      rel_r    <= skc_pkg::RELEASE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        skc_pkg::REG_MAKEUP:  makeup_r <= cfg_wdata[DB-1:0];
        skc_pkg::REG_THRESH:  thr_r    <= cfg_wdata[DB-1:0];
        skc_pkg::REG_INV_RAT: inv_r    <= cfg_wdata[16:0];
        skc_pkg::REG_KNEE:    knee_r   <= cfg_wdata[0];
        skc_pkg::REG_ATTACK:  att_r    <= cfg_wdata[15:0];
        skc_pkg::REG_RELEASE: rel_r    <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // sequencer: one sample at a time through shared multipliers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      level_r     <= skc_pkg::DET_RESET;
      out_valid_r <= 1'b0;
    end else begin
      // the output state sets valid itself whenever it can proceed
      if (out_valid_r && out_ready && (state_r != S_OUT)) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (item_valid) begin
            neg_r <= it_neg;
            mag_r <= it_mag;
            z_r   <= it_mag;
            p_r   <= PW'(SB - 1);
            if (it_blk) level_r <= skc_pkg::DET_RESET;
            if (it_zero) begin
              lvl_r   <= LVL_FLOOR;
              state_r <= S_GAIN;
            end else begin
              state_r <= S_NORM;
            end
          end
        end
        // leading one search, one bit a cycle
        S_NORM: begin
          if (z_r[SB-1]) begin
            y_r     <= z_ext[SB+30 -: 31];
            fr_r    <= '0;
            cnt_r   <= '0;
            state_r <= S_SQR;
          end else begin
            z_r <= z_r << 1;
            p_r <= p_r - 1'b1;
          end
        end
        // sixteen squarings give the log2 fraction
        S_SQR: begin
          fr_r  <= {fr_r[14:0], sq_hi[31]};
          y_r   <= sq_hi[31] ? sq_hi[31:1] : sq_hi[30:0];
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd15) state_r <= S_L2;
        end
        S_L2: begin
          ldb_r   <= l2 * skc_pkg::K_DB_PER_LOG2;
          state_r <= S_LVL;
        end
        S_LVL: begin
          if (lsh < DB_LO) lvl_r <= LVL_FLOOR;
          else if (lsh > DB_HI) lvl_r <= DB'(DB_HI);
          else lvl_r <= lsh[DB-1:0];
          state_r <= S_GAIN;
        end
        // pick the curve segment
        S_GAIN: begin
          ek2_r <= ek * ek;
          lin_r <= d[DB-1:0] * m_w;
          m_r   <= m_w;
          if (knee_r ? (d2 < -KNEE_W_I) : (d2 < 0)) mode_r <= RED_ZERO;
          else if (knee_r && (d2 <= KNEE_W_I)) mode_r <= RED_SOFT;
          else mode_r <= RED_LIN;
          state_r <= S_KNEE1;
        end
        S_KNEE1: begin
          kx_r    <= ek2_r * m_r;
          state_r <= S_KNEE2;
        end
        // divide by twice the knee width: a shift, then by five through its reciprocal
        S_KNEE2: begin
          q5_r    <= ky * skc_pkg::RECIP5_Q26;
          state_r <= S_RED;
        end
        S_RED: begin
          red_r   <= (red_full > 25'(skc_pkg::DET_MAX)) ? skc_pkg::DET_MAX : red_full[23:0];
          state_r <= S_DET;
        end
        S_DET: begin
          level_r <= acc[39:16];
          state_r <= S_CTRL;
        end
        S_CTRL: begin
          if (gw < DB_LO) g_r <= LVL_FLOOR;
          else if (gw > DB_HI) g_r <= DB'(DB_HI);
          else g_r <= gw[DB-1:0];
          state_r <= S_EXPE;
        end
        S_EXPE: begin
          ep_r    <= g_r * skc_pkg::K_LOG2_PER_DB;
          state_r <= S_EXPX;
        end
        S_EXPX: begin
          n_r     <= ee[23:16];
          x_r     <= fx[45:16];
          t_r     <= skc_pkg::ONE_Q30;
          k_r     <= 3'd7;
          state_r <= S_H1;
        end
        // horner steps of 2^f, each through S_H1, S_H2 and S_H3
        S_H1: begin
          hp_r    <= x_r * t_r;
          state_r <= S_H2;
        end
        S_H2: begin
          v_r     <= v_w;
          qm_r    <= v_w * skc_pkg::horner_recip(k_r);
          state_r <= S_H3;
        end
        S_H3: begin
          t_r <= skc_pkg::ONE_Q30 + ((rem >= 35'(k_r)) ? (q0 + 32'd1) : q0);
          k_r <= k_r - 3'd1;
          state_r <= (k_r == 3'd1) ? S_MUL : S_H1;
        end
        S_MUL: begin
          pr_r    <= mag_r * t_r;
          state_r <= S_OUT;
        end
        // hand the result to the output register once it is free
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_sample_r <= res;
            out_gain_r   <= g_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

>>> design/feedforward_soft_knee_compressor_top.sv
// top level of the feedforward soft-knee compressor
// depends on skc_pkg, skc_if, skc_front, skc_fifo and skc_back
//
// usage:
//   in_ch carries one signed sample and a block_start flag per word; a
//   word is taken when valid and ready are both high. block_start reloads
//   the detector level to 0.01 dB before that sample is processed.
//   out_ch returns exactly one word per input: the gain-applied, saturated
//   sample and the control gain in dB.
//   cfg_we/cfg_addr/cfg_wdata write one register per cycle; write only
//   while the block holds no unfinished sample.
// timing:
//   the back end handles one sample at a time. a nonzero sample passes
//   the leading-one search (one bit a cycle), sixteen log2 squarings
//   and seven horner steps of 2^f; a zero sample skips the search, the
//   squarings and the dB conversion and goes straight to the gain curve.
// reset: rst_n is synchronous and active low; it empties the queue, drops
//   any result and restores register and detector defaults.
// stall: a held output keeps its word; the front register and a
//   two-entry queue keep taking samples until full.
module feedforward_soft_knee_compressor_top #(
  parameter int SAMPLE_BITS  = skc_pkg::SAMPLE_BITS_DEF,
  parameter int DB_FRAC_BITS = skc_pkg::DB_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  skc_in_if.sink                            in_ch,
  skc_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [skc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [((DB_FRAC_BITS+8)>17 ? (DB_FRAC_BITS+8) : 17)-1:0] cfg_wdata
);

  localparam int IW = SAMPLE_BITS + 3;

  logic          fr_valid, fr_ready;
  logic [IW-1:0] fr_data;
  logic          q_valid, q_ready;
  logic [IW-1:0] q_data;

  // classify incoming words
  skc_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .item_valid (fr_valid),
    .item_ready (fr_ready),
    .item_data  (fr_data)
  );

  // decoupling queue
  skc_fifo #(.W(IW)) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_data  (fr_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  // gain computation and output register
  skc_back #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .DB_FRAC_BITS (DB_FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item_data  (q_data),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_sample (out_ch.sample_out),
    .out_gain   (out_ch.gain_db)
  );

endmodule

>>> design/skc_checker.sv
// port-level checks for the compressor top, attached by bind
// depends on the top level's channel ports
module skc_checker #(
  parameter int SAMPLE_BITS  = skc_pkg::SAMPLE_BITS_DEF,
  parameter int DB_FRAC_BITS = skc_pkg::DB_FRAC_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [SAMPLE_BITS-1:0]        out_sample,
  input logic [DB_FRAC_BITS+7:0]       out_gain
);

  logic [3:0] pend_r;

  // words taken in but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 4'd0;
    end else begin
      case ({in_valid && in_ready, out_valid && out_ready})
        2'b10:   pend_r <= pend_r + 4'd1;
        2'b01:   pend_r <= pend_r - 4'd1;
        default: pend_r <= pend_r;
      endcase
    end
  end

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_sample) && $stable(out_gain))
    else $error("result payload changed while stalled");

  // no result without an outstanding sample
  a_owed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 4'd0)
    else $error("result with no sample pending");

  // front register, queue, back end and output hold at most five words
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 4'd5)
    else $error("more samples in flight than storage");

endmodule

bind feedforward_soft_knee_compressor_top skc_checker #(
  .SAMPLE_BITS  (SAMPLE_BITS),
  .DB_FRAC_BITS (DB_FRAC_BITS)
) u_skc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_sample (out_ch.sample_out),
  .out_gain   (out_ch.gain_db)
);

>>> tb/sv/feedforward_soft_knee_compressor_top_tb.sv
`timescale 1ns / 100ps
// testbench for the feedforward soft-knee compressor: random and directed samples
// through several register settings, checked against a bit-exact predictor
// depends on skc_pkg, skc_if and the compressor top level
module feedforward_soft_knee_compressor_top_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 120;

  typedef struct packed {
    logic signed [23:0] sample;
    logic               block_start;
  } sample_word_t;

  typedef struct packed {
    logic signed [23:0] sample_out;
    logic signed [15:0] gain_db;
  } gain_word_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [16:0] cfg_wdata;

  skc_in_if  in_ch ();
  skc_out_if out_ch ();

  feedforward_soft_knee_compressor_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // shadow registers and detector
  logic signed [15:0] makeup_q, thresh_q;
  logic [16:0]        inv_ratio_q;
  logic               knee_q;
  logic [15:0]        attack_q, release_q;
  longint             det_level;

  sample_word_t pending_words[$];
  gain_word_t   expected_gains[$];
  int           fail_count = 0;
  int           words_sent = 0;
  int           words_checked = 0;
  int           phase_count = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // dB level of a magnitude, Q8.8
  function automatic longint mag_to_db(input longint mag);
    longint y, fr, l2, v;
    int p;
    y = 0;
    fr = 0;
    p = 0;
    if (mag == 0) return -32768;
    while (p < 62 && (mag >> (p + 1)) != 0) p++;
    y = mag << (30 - p);
    for (int i = 0; i < 16; i++) begin
      y = (y * y) >> 30;
      fr = fr << 1;
      if (y >= 64'sd2147483648) begin
        fr = fr | 1;
        y = y >> 1;
      end
    end
    l2 = longint'(p - 23) * 65536 + fr;
    v = (l2 * 394566 + (64'sd1 << 23)) >>> 24;
    if (v < -32768) v = -32768;
    if (v > 32767) v = 32767;
    return v;
  endfunction

  // 2^f for a Q.16 fraction, Q1.30
  function automatic longint exp2_q30(input longint f);
    longint x, t;
    x = (f * 744261118) >> 16;
    t = 64'sd1073741824;
    for (int k = 7; k >= 1; k--) t = 64'sd1073741824 + ((x * t) >> 30) / k;
    return t;
  endfunction

  // compressor gain and output for one sample; advances the detector
  function automatic gain_word_t compress(input sample_word_t w);
    gain_word_t o;
    longint x, mag, lvl, d, kw, r, red, a, cv, g, e, n, prod, q, res, ek;
    int s;
    x = w.sample;
    mag = (x < 0) ? -x : x;
    r = (inv_ratio_q > 17'd65536) ? 65536 : inv_ratio_q;
    if (w.block_start) det_level = skc_pkg::DET_RESET;
    lvl = mag_to_db(mag);
    kw = knee_q ? 5120 : 0;
    d = lvl - thresh_q;
    if (2 * d < -kw) red = 0;
    else if (kw > 0 && 2 * d <= kw && -2 * d <= kw) begin
      ek = d + kw / 2;
      red = ((65536 - r) * (ek * ek)) / (2 * kw * 65536);
    end else red = (d * (65536 - r)) >> 16;
    red = red << 8;
    if (red > skc_pkg::DET_MAX) red = skc_pkg::DET_MAX;
    a = (red > det_level) ? attack_q : release_q;
    det_level = (a * det_level + (65536 - a) * red + 32768) >> 16;
    cv = longint'(makeup_q) * 256 - det_level;
    g = cv >>> 8;
    if (g < -32768) g = -32768;
    if (g > 32767) g = 32767;
    e = (g * 10885) >>> 8;
    n = e >>> 16;
    prod = mag * exp2_q30(e & 64'hFFFF);
    s = 30 - int'(n);
    if (s < 1) s = 1;
    q = (s >= 63) ? 0 : ((prod + (64'sd1 << (s - 1))) >> s);
    if (x < 0) res = (q > 8388608) ? -8388608 : -q;
    else res = (q > 8388607) ? 8388607 : q;
    o.sample_out = res[23:0];
    o.gain_db = g[15:0];
    return o;
  endfunction

  // sender: bursts of random length with random gaps
  int burst_left = 4;
  int gap_left = 0;
  always @(posedge clk) begin
    sample_word_t nxt;
    logic         offer;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        expected_gains.push_back(compress({in_ch.sample_in, in_ch.block_start}));
        words_sent++;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
        end
      end
      offer = 1'b0;
      if (gap_left > 0) gap_left--;
      else if (pending_words.size() > 0) begin
        nxt = pending_words.pop_front();
        offer = 1'b1;
        in_ch.sample_in <= nxt.sample;
        in_ch.block_start <= nxt.block_start;
      end
      in_ch.valid <= offer;
    end
  end

  // receiver: stall pattern in changing modes, one long hold-off; checks results
  int stall_mode = 0;
  int mode_left = 0;
  int long_hold = 0;
  bit long_hold_done = 1'b0;
  always @(posedge clk) begin
    gain_word_t exp_w;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_gains.size() == 0) begin
          $error("result word with no expectation: sample_out %0d gain_db %0d",
                 out_ch.sample_out, out_ch.gain_db);
          fail_count++;
        end else begin
          exp_w = expected_gains.pop_front();
          if (out_ch.sample_out !== exp_w.sample_out) begin
            $error("sample_out expected %0d actual %0d", exp_w.sample_out, out_ch.sample_out);
            fail_count++;
          end
          if (out_ch.gain_db !== exp_w.gain_db) begin
            $error("gain_db expected %0d actual %0d", exp_w.gain_db, out_ch.gain_db);
            fail_count++;
          end
        end
        words_checked++;
      end
      // hold off in the middle of a long phase so the block fills up
      if (!long_hold_done && words_checked == 190) begin
        long_hold_done = 1'b1;
        long_hold = 400;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 200);
      end else mode_left--;
      if (long_hold > 0) begin
        long_hold--;
        out_ch.ready <= 1'b0;
      end else case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        default: out_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // run limit
  int cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // register write at the next edge; shadow copy follows the port masking
  task automatic write_reg(input logic [2:0] idx, input logic [16:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      skc_pkg::REG_MAKEUP:  makeup_q = val[15:0];
      skc_pkg::REG_THRESH:  thresh_q = val[15:0];
      skc_pkg::REG_INV_RAT: inv_ratio_q = val;
      skc_pkg::REG_KNEE:    knee_q = val[0];
      skc_pkg::REG_ATTACK:  attack_q = val[15:0];
      skc_pkg::REG_RELEASE: release_q = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [16:0] mk, input logic [16:0] th, input logic [16:0] ir,
                          input logic [16:0] kn, input logic [16:0] at, input logic [16:0] rl);
    write_reg(skc_pkg::REG_MAKEUP, mk);
    write_reg(skc_pkg::REG_THRESH, th);
    write_reg(skc_pkg::REG_INV_RAT, ir);
    write_reg(skc_pkg::REG_KNEE, kn);
    write_reg(skc_pkg::REG_ATTACK, at);
    write_reg(skc_pkg::REG_RELEASE, rl);
    // out-of-range index must leave everything alone
    write_reg(3'd6, 17'h1FFFF);
    write_reg(3'd7, 17'h00000);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // random samples over all magnitudes, with occasional detector reloads
  task automatic push_random(input int count);
    sample_word_t w;
    logic [23:0]  raw;
    for (int i = 0; i < count; i++) begin
      raw = 24'($urandom);
      case ($urandom_range(0, 5))
        0: w.sample = raw;
        1: w.sample = 24'd0;
        default: w.sample = $signed(raw) >>> $urandom_range(0, 23);
      endcase
      w.block_start = ($urandom_range(0, 15) == 0);
      pending_words.push_back(w);
    end
  endtask

  // wait for every expected result, then let the back end settle
  task automatic drain;
    wait (pending_words.size() == 0 && !in_ch.valid && expected_gains.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    phase_count++;
  endtask

  // stimulus
  initial begin
    in_ch.valid = 1'b0;
    in_ch.sample_in = '0;
    in_ch.block_start = 1'b0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    makeup_q = 0;
    thresh_q = 0;
    inv_ratio_q = skc_pkg::INV_RATIO_RST;
    knee_q = 1'b1;
    attack_q = skc_pkg::ATTACK_RST;
    release_q = skc_pkg::RELEASE_RST;
    det_level = skc_pkg::DET_RESET;
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes and detector reloads at reset settings
    pending_words.push_back({24'sh7FFFFF, 1'b0});
    pending_words.push_back({24'sh800000, 1'b0});
    pending_words.push_back({24'sh000000, 1'b0});
    pending_words.push_back({24'sh000001, 1'b0});
    pending_words.push_back({24'shFFFFFF, 1'b1});
    pending_words.push_back({24'sh400000, 1'b0});
    pending_words.push_back({24'shC00000, 1'b0});
    pending_words.push_back({24'sh000000, 1'b1});
    pending_words.push_back({24'sh555555, 1'b0});
    pending_words.push_back({24'shAAAAAA, 1'b1});
    push_random(60);
    drain();

    // soft knee 4:1 at -20 dB with makeup; knee edges around threshold
    set_regs(17'd1536, 17'h1EC00, 17'd16384, 17'd1, 17'd60000, 17'd65000);
    pending_words.push_back({24'sh7FFFFF, 1'b1});
    pending_words.push_back({24'sh0D1B71, 1'b0});
    pending_words.push_back({24'sh02A000, 1'b0});
    pending_words.push_back({24'sh00C800, 1'b0});
    push_random(80);
    drain();

    // hard knee limiter, instant detector, threshold hit exactly
    set_regs(17'd0, 17'h1F600, 17'd0, 17'h1FFFE, 17'h10000, 17'h10000);
    pending_words.push_back({24'sh28A2C8, 1'b0});
    pending_words.push_back({24'sh7FFFFF, 1'b0});
    push_random(80);
    drain();

    // extremes: full makeup, lowest threshold, ratio near one, slowest poles
    set_regs(17'h07FFF, 17'h08000, 17'd65535, 17'd0, 17'd65535, 17'd65535);
    push_random(80);
    drain();

    // opposite extremes: ratio register above one, attack instant
    set_regs(17'h08000, 17'h07FFF, 17'd100000, 17'd1, 17'd0, 17'd65535);
    push_random(60);
    drain();

    // random settings, sender pauses between them
    repeat (3) begin
      set_regs(17'($urandom), {$urandom_range(0, 1) ? 1'b1 : 1'b0,
               16'($urandom_range(55000, 65535))},
               17'($urandom_range(0, 70000)), 17'($urandom), 17'($urandom), 17'($urandom));
      push_random(40);
      drain();
    end

    $display("summary: %0d samples in %0d register settings, %0d results checked",
             words_sent, phase_count, words_checked);
    $display("summary: hard and soft knee, limiter, out-of-range ratio, detector reloads");
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
